@@ hw/rtl/tsrb_pkg.sv @@
package tsrb_pkg;

	localparam int ROW_W        = 11;
	localparam int HGT_W        = 12;
	localparam int DEC_W        = 7;
	localparam int PIX_W        = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;
	localparam int IMAGE_HEIGHT = 2048;
	localparam int TANH_DEPTH   = 256;
	localparam int Q            = 16;

	localparam int IDX_W  = $clog2(TANH_DEPTH + 1);
	localparam int TV_W   = Q + 1;
	localparam int RCP_W  = Q + 1;
	localparam int U_W    = HGT_W + 2;
	localparam int V_W    = U_W + RCP_W + 1;
	localparam int MAG_W  = Q + 2;
	localparam int T_W    = Q + 3;
	localparam int ALPHA_W = Q;
	localparam int NCH    = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [HGT_W-1:0] BAND_HEIGHT_RST = HGT_W'(20);
	localparam logic [DEC_W-1:0] DECAY_RST       = DEC_W'(6);

	localparam logic [63:0] TANH_STEP = ((64'd8 << 24) + (TANH_DEPTH >> 1)) / TANH_DEPTH;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAND_TOP    = 2'd0,
		REG_BAND_HEIGHT = 2'd1,
		REG_DECAY       = 2'd2
	} cfg_reg_t;

	typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [1:0]            sign;
		logic [1:0]            sat;
		logic [1:0][MAG_W-1:0] mag;
		pix_t                  sharp;
		pix_t                  blur;
	} item_t;

	typedef struct packed {
		logic empty;
		logic almost_full;
	} q_status_t;

	typedef logic [TANH_DEPTH:0][TV_W-1:0] tanh_rom_t;
	typedef logic [(1 << DEC_W)-1:0][RCP_W-1:0] recip_rom_t;

	function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		int          i;
		quo = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			quo = quo << 1;
			if (rem >= den) begin
				rem    = rem - den;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic tanh_rom_t build_tanh_rom();
		tanh_rom_t   rom;
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] p;
		logic [63:0] one;
		int          n;
		int          k;
		one  = 64'd1 << 24;
		s    = TANH_STEP;
		term = one;
		e    = one;
		p    = one;
		for (n = 1; n < 40 && term != 0; n++) begin
			term = const_div((term * s) >> 24, 64'(n));
			e    = e + term;
		end
		rom[0] = '0;
		for (k = 1; k <= TANH_DEPTH; k++) begin
			p      = (p * e + (one >> 1)) >> 24;
			rom[k] = TV_W'(const_div(((p - one) << 16) + ((p + one) >> 1), p + one));
		end
		return rom;
	endfunction

	function automatic recip_rom_t build_recip_rom();
		recip_rom_t rom;
		int         i;
		int         dc;
		for (i = 0; i < (1 << DEC_W); i++) begin
			dc     = (i == 0) ? 1 : i;
			rom[i] = RCP_W'(const_div(64'(65536 + (dc >> 1)), 64'(dc)));
		end
		return rom;
	endfunction

	localparam tanh_rom_t  TANH_ROM  = build_tanh_rom();
	localparam recip_rom_t RECIP_ROM = build_recip_rom();

endpackage

@@ hw/rtl/tsrb_front.sv @@
module tsrb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [tsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsrb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            take,
	input  logic [tsrb_pkg::ROW_W-1:0]      row,
	input  tsrb_pkg::pix_t                  sharp,
	input  tsrb_pkg::pix_t                  blur,
	output logic                            push,
	output tsrb_pkg::item_t                 item
);
	import tsrb_pkg::*;

	logic [ROW_W-1:0] band_top_q;
	logic [HGT_W-1:0] band_height_q;
	logic [DEC_W-1:0] decay_q;

	logic [HGT_W-1:0]        bh;
	logic signed [U_W-1:0]   u1;
	logic signed [U_W-1:0]   u2;

	logic                    valid_s1;
	logic signed [U_W-1:0]   u1_s1;
	logic signed [U_W-1:0]   u2_s1;
	logic [RCP_W-1:0]        recip_s1;
	pix_t                    sharp_s1;
	pix_t                    blur_s1;

	logic signed [V_W-1:0]   v [2];
	logic [V_W-1:0]          mag [2];

	logic                    valid_s2;
	item_t                   item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_top_q    <= '0;
			band_height_q <= BAND_HEIGHT_RST;
			decay_q       <= DECAY_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BAND_TOP:    band_top_q    <= cfg_data[ROW_W-1:0];
				REG_BAND_HEIGHT: band_height_q <= cfg_data[HGT_W-1:0];
				REG_DECAY:       decay_q       <= cfg_data[DEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (band_height_q == '0) begin
			bh = HGT_W'(1);
		end else if (int'(band_height_q) > IMAGE_HEIGHT) begin
			bh = HGT_W'(IMAGE_HEIGHT);
		end else begin
			bh = band_height_q;
		end
		u1 = $signed({{(U_W-ROW_W){1'b0}}, row}) - $signed({{(U_W-ROW_W){1'b0}}, band_top_q});
		u2 = u1 - $signed({2'b00, bh[HGT_W-1:1], 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			u1_s1    <= u1;
			u2_s1    <= u2;
			recip_s1 <= RECIP_ROM[decay_q];
			sharp_s1 <= sharp;
			blur_s1  <= blur;
		end
	end

	always_comb begin
		v[0] = u1_s1 * $signed({1'b0, recip_s1});
		v[1] = u2_s1 * $signed({1'b0, recip_s1});
		for (int i = 0; i < 2; i++) begin
			mag[i] = v[i][V_W-1] ? V_W'(-v[i]) : V_W'(v[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < 2; i++) begin
				item_s2.sign[i] <= v[i][V_W-1];
				item_s2.sat[i]  <= |mag[i][V_W-1:MAG_W];
				item_s2.mag[i]  <= mag[i][MAG_W-1:0];
			end
			item_s2.sharp <= sharp_s1;
			item_s2.blur  <= blur_s1;
		end
	end

	assign push = valid_s2;
	assign item = item_s2;

endmodule

@@ hw/rtl/tsrb_queue.sv @@
module tsrb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tsrb_pkg::item_t      push_item,
	input  logic                 pop,
	output tsrb_pkg::item_t      head,
	output tsrb_pkg::q_status_t  status
);
	import tsrb_pkg::*;

	item_t            slot_q [QUEUE_DEPTH];
	logic [QA_W-1:0]  wr_ptr_q;
	logic [QA_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head               = slot_q[rd_ptr_q];
	assign status.empty       = (count_q == '0);
	assign status.almost_full = (count_q >= QC_W'(QUEUE_DEPTH - 2));

endmodule

@@ hw/rtl/tsrb_back.sv @@
module tsrb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsrb_pkg::q_status_t         status,
	input  tsrb_pkg::item_t             head,
	output logic                        pop,
	output logic                        done,
	output tsrb_pkg::pix_t              result
);
	import tsrb_pkg::*;

	localparam int P_W = MAG_W + IDX_W;
	localparam int IP_W = TV_W + Q + 1;

	logic [P_W-1:0]   prod [2];
	logic [P_W-1:0]   kraw [2];
	logic [IDX_W-1:0] k [2];
	logic [IDX_W-1:0] k1 [2];
	logic [TV_W-1:0]  lo [2];
	logic [TV_W-1:0]  hi [2];

	logic                   valid_s3;
	logic [1:0]             sign_s3;
	logic [1:0]             sat_s3;
	logic [TV_W-1:0]        lo_s3 [2];
	logic [TV_W-1:0]        dlt_s3 [2];
	logic [Q-1:0]           frac_s3 [2];
	pix_t                   sharp_s3;
	pix_t                   blur_s3;

	logic [IP_W-1:0]        ip [2];
	logic [T_W-2:0]         r [2];
	logic                   valid_s4;
	logic signed [T_W-1:0]  t_s4 [2];
	pix_t                   sharp_s4;
	pix_t                   blur_s4;

	logic signed [T_W:0]    diff;
	logic [T_W-1:0]         half;
	logic                   valid_s5;
	logic [ALPHA_W-1:0]     alpha_s5;
	pix_t                   sharp_s5;
	pix_t                   blur_s5;

	logic                             valid_s6;
	logic [NCH-1:0][ALPHA_W+PIX_W:0]  ps_s6;
	logic [NCH-1:0][ALPHA_W+PIX_W:0]  pb_s6;

	logic [ALPHA_W+PIX_W+1:0]         sum [NCH];
	logic [ALPHA_W+PIX_W+1:0]         scaled [NCH];
	logic                             done_q;
	pix_t                             result_q;

	assign pop = !status.empty;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod[i] = P_W'(head.mag[i]) * P_W'(TANH_DEPTH);
			kraw[i] = prod[i] >> (Q + 2);
			k[i]    = (kraw[i] >= P_W'(TANH_DEPTH)) ? IDX_W'(TANH_DEPTH - 1) : kraw[i][IDX_W-1:0];
			k1[i]   = k[i] + 1'b1;
			lo[i]   = TANH_ROM[k[i]];
			hi[i]   = (TANH_ROM[k1[i]] < lo[i]) ? lo[i] : TANH_ROM[k1[i]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s3 <= pop;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 2; i++) begin
				lo_s3[i]   <= lo[i];
				dlt_s3[i]  <= hi[i] - lo[i];
				frac_s3[i] <= prod[i][Q+1:2];
			end
			sign_s3  <= head.sign;
			sat_s3   <= head.sat;
			sharp_s3 <= head.sharp;
			blur_s3  <= head.blur;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			ip[i] = IP_W'(dlt_s3[i]) * IP_W'(frac_s3[i]) + IP_W'(32768);
			if (sat_s3[i]) begin
				r[i] = (T_W-1)'(1 << Q);
			end else begin
				r[i] = (T_W-1)'(lo_s3[i]) + (T_W-1)'(ip[i] >> Q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			for (int i = 0; i < 2; i++) begin
				t_s4[i] <= sign_s3[i] ? -$signed({1'b0, r[i]}) : $signed({1'b0, r[i]});
			end
			sharp_s4 <= sharp_s3;
			blur_s4  <= blur_s3;
		end
	end

	always_comb begin
		diff = (T_W+1)'(t_s4[0]) - (T_W+1)'(t_s4[1]);
		if (diff[T_W]) begin
			half = '0;
		end else begin
			half = (diff[T_W-1:0] + 1'b1) >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			alpha_s5 <= (half > T_W'((1 << ALPHA_W) - 1)) ? '1 : half[ALPHA_W-1:0];
			sharp_s5 <= sharp_s4;
			blur_s5  <= blur_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			for (int c = 0; c < NCH; c++) begin
				ps_s6[c] <= (ALPHA_W+PIX_W+1)'(alpha_s5) * (ALPHA_W+PIX_W+1)'(sharp_s5[c]);
				pb_s6[c] <= ((ALPHA_W+PIX_W+1)'(1 << ALPHA_W) - (ALPHA_W+PIX_W+1)'(alpha_s5))
					* (ALPHA_W+PIX_W+1)'(blur_s5[c]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			sum[c]    = (ALPHA_W+PIX_W+2)'(ps_s6[c]) + (ALPHA_W+PIX_W+2)'(pb_s6[c])
				+ (ALPHA_W+PIX_W+2)'(32768);
			scaled[c] = sum[c] >> ALPHA_W;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s6) begin
			for (int c = 0; c < NCH; c++) begin
				result_q[c] <= (scaled[c] > (ALPHA_W+PIX_W+2)'(255)) ? '1 : scaled[c][PIX_W-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hw/rtl/tilt_shift_row_blend.sv @@
// The block blends one sharp and one blurred BGR pixel per beat with a weight that follows a
// soft band of rows, and it takes a new pixel on every clock while busy is low. The result
// appears on done and the out ports for one cycle only; the receiver cannot stall, so it must
// capture every result in that cycle. Each pixel passes through two front stages that form
// the row offsets and scale them by the decay reciprocal, then through the queue, and then
// through five back stages for the tanh table interpolation, the weight and the blend.
// Configuration writes are always accepted and take effect for the next pixel; they should
// only be made while no pixel is in flight.
module tilt_shift_row_blend (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsrb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [tsrb_pkg::ROW_W-1:0]      row,
	input  logic [tsrb_pkg::PIX_W-1:0]      sharp_b,
	input  logic [tsrb_pkg::PIX_W-1:0]      sharp_g,
	input  logic [tsrb_pkg::PIX_W-1:0]      sharp_r,
	input  logic [tsrb_pkg::PIX_W-1:0]      blur_b,
	input  logic [tsrb_pkg::PIX_W-1:0]      blur_g,
	input  logic [tsrb_pkg::PIX_W-1:0]      blur_r,
	output logic                            done,
	output logic [tsrb_pkg::PIX_W-1:0]      out_b,
	output logic [tsrb_pkg::PIX_W-1:0]      out_g,
	output logic [tsrb_pkg::PIX_W-1:0]      out_r
);
	import tsrb_pkg::*;

	logic      take;
	logic      push;
	logic      pop;
	item_t     push_item;
	item_t     head;
	q_status_t status;
	pix_t      sharp;
	pix_t      blur;
	pix_t      result;

	assign cfg_ready = 1'b1;
	assign busy      = status.almost_full;
	assign take      = start && !busy;
	assign sharp     = {sharp_r, sharp_g, sharp_b};
	assign blur      = {blur_r, blur_g, blur_b};

	tsrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.row       (row),
		.sharp     (sharp),
		.blur      (blur),
		.push      (push),
		.item      (push_item)
	);

	tsrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	tsrb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	assign out_b = result[0];
	assign out_g = result[1];
	assign out_r = result[2];

endmodule

@@ hw/rtl/tsrb_checker.sv @@
module tsrb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic                            start,
	input logic                            busy,
	input logic [tsrb_pkg::PIX_W-1:0]      sharp_g,
	input logic [tsrb_pkg::PIX_W-1:0]      blur_g,
	input logic                            done,
	input logic [tsrb_pkg::PIX_W-1:0]      out_g
);
	import tsrb_pkg::*;

	localparam int LATENCY = 8;

	// Every accepted beat yields exactly one result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LATENCY))
		else $error("result without an accepted pixel");

	// Equal sharp and blurred green channels must blend to that same value whatever the weight.
	a_equal_inputs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sharp_g == blur_g) |-> ##LATENCY (out_g == $past(sharp_g, LATENCY)))
		else $error("blend of equal channels changed the value");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind tilt_shift_row_blend tsrb_checker u_tsrb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.start     (start),
	.busy      (busy),
	.sharp_g   (sharp_g),
	.blur_g    (blur_g),
	.done      (done),
	.out_g     (out_g)
);
